// File: src/ntor_pkg.sv
// Shared constants, types and codes for the neighbor table.
`timescale 1ns / 1ps
`default_nettype none

package ntor_pkg;

    localparam int TABLE_DEPTH = 20;
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam int ID_W = 8;
    localparam int WORD_W = 32;
    localparam int FIELD5_W = 5;

    localparam logic [WORD_W-1:0] TIMEOUT_RESET = 32'd2000;

    localparam logic FUNC_UPDATE = 1'b0;
    localparam logic FUNC_PURGE = 1'b1;

    typedef enum logic [1:0] {
        OUT_UPDATED  = 2'd0,
        OUT_APPENDED = 2'd1,
        OUT_REPLACED = 2'd2,
        OUT_PURGED   = 2'd3
    } outcome_t;

    typedef struct packed {
        logic [ID_W-1:0]   node_id;
        logic [WORD_W-1:0] seen_time;
        logic [WORD_W-1:0] pos_x_bits;
        logic [WORD_W-1:0] pos_y_bits;
        logic [WORD_W-1:0] pos_z_bits;
        logic [WORD_W-1:0] speed_bits;
        logic [WORD_W-1:0] heading_bits;
    } entry_t;

endpackage

`default_nettype wire

// File: src/ntor_if.sv
// Input and result channel interfaces of the neighbor table.
`timescale 1ns / 1ps
`default_nettype none

interface ntor_in_if
    import ntor_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              func;
    logic [ID_W-1:0]   node_id;
    logic [WORD_W-1:0] pos_x_bits;
    logic [WORD_W-1:0] pos_y_bits;
    logic [WORD_W-1:0] pos_z_bits;
    logic [WORD_W-1:0] speed_bits;
    logic [WORD_W-1:0] heading_bits;
    logic [WORD_W-1:0] seen_time;
    logic [WORD_W-1:0] now_time;

    modport source (
        output valid, func, node_id, pos_x_bits, pos_y_bits, pos_z_bits,
               speed_bits, heading_bits, seen_time, now_time,
        input  ready
    );
    modport sink (
        input  valid, func, node_id, pos_x_bits, pos_y_bits, pos_z_bits,
               speed_bits, heading_bits, seen_time, now_time,
        output ready
    );
endinterface

interface ntor_out_if
    import ntor_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [1:0]          outcome;
    logic [FIELD5_W-1:0] slot;
    logic [ID_W-1:0]     evicted_id;
    logic [FIELD5_W-1:0] removed_count;
    logic [FIELD5_W-1:0] entry_count;

    modport source (
        output valid, outcome, slot, evicted_id, removed_count, entry_count,
        input  ready
    );
    modport sink (
        input  valid, outcome, slot, evicted_id, removed_count, entry_count,
        output ready
    );
endinterface

`default_nettype wire

// File: src/neighbor_table_oldest_replace.sv
// Neighbor table: keyed update with oldest replacement, and timeout purge.
// Each item, update or purge, is worked from transfer to result by one pass over the entry
// memory through its registered read port and a shared compare unit. One item is in work at
// a time; the next is taken in the cycle after the result enters the output register. Reset
// empties the table and sets the timeout to 2000; memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module neighbor_table_oldest_replace
    import ntor_pkg::*;
(
    input  wire              clk,
    input  wire              rst_n,
    input  wire              timeout_we,
    input  wire [WORD_W-1:0] timeout_wdata,
    ntor_in_if.sink          items,
    ntor_out_if.source       results
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_DONE
    } state_t;

    state_t state_reg;

    entry_t mem [TABLE_DEPTH];
    entry_t rd_data_reg;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_wa;
    entry_t            mem_wd;

    logic [WORD_W-1:0] timeout_reg;
    logic [CNT_W-1:0]  count_reg;

    logic              func_reg;
    entry_t            item_reg;
    logic [WORD_W-1:0] now_reg;

    logic [CNT_W-1:0]  rd_idx_reg;
    logic              proc_vld_reg;
    logic [CNT_W-1:0]  proc_idx_reg;

    logic              found_reg;
    logic [CNT_W-1:0]  hit_idx_reg;
    logic [WORD_W-1:0] min_seen_reg;
    logic [CNT_W-1:0]  min_idx_reg;
    logic [ID_W-1:0]   min_id_reg;
    logic [CNT_W-1:0]  keep_reg;
    logic [CNT_W-1:0]  removed_reg;

    outcome_t          res_outcome_reg;
    logic [CNT_W-1:0]  res_slot_reg;
    logic [ID_W-1:0]   res_evicted_reg;

    logic              out_valid_reg;
    outcome_t          out_outcome_reg;
    logic [CNT_W-1:0]  out_slot_reg;
    logic [ID_W-1:0]   out_evicted_reg;
    logic [CNT_W-1:0]  out_removed_reg;
    logic [CNT_W-1:0]  out_count_reg;

    // Shared compare unit: oldest search for updates, age test for purges.
    logic [WORD_W-1:0] age;
    logic [WORD_W-1:0] cmp_a;
    logic [WORD_W-1:0] cmp_b;
    logic              cmp_lt;

    logic              table_full;
    logic [CNT_W-1:0]  slot_sel;
    outcome_t          outcome_sel;
    logic              scan_end;

    assign age = now_reg - rd_data_reg.seen_time;

    always_comb
    begin
        if (func_reg == FUNC_PURGE)
        begin
            cmp_a = timeout_reg;
            cmp_b = age;
        end
        else
        begin
            cmp_a = rd_data_reg.seen_time;
            cmp_b = min_seen_reg;
        end
    end

    assign cmp_lt = cmp_a < cmp_b;

    assign table_full = (count_reg >= CNT_W'(TABLE_DEPTH));
    assign scan_end = (rd_idx_reg == count_reg) && !proc_vld_reg;

    always_comb
    begin
        if (found_reg)
        begin
            slot_sel = hit_idx_reg;
            outcome_sel = OUT_UPDATED;
        end
        else if (!table_full)
        begin
            slot_sel = count_reg;
            outcome_sel = OUT_APPENDED;
        end
        else
        begin
            slot_sel = min_idx_reg;
            outcome_sel = OUT_REPLACED;
        end
    end

    // Survivors of a purge move down to the keep position; it never passes the
    // entry being read, so the copy cannot clobber an unread entry.
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = keep_reg[IDX_W-1:0];
        mem_wd = rd_data_reg;
        if (state_reg == S_SCAN && proc_vld_reg && func_reg == FUNC_PURGE && !cmp_lt)
        begin
            mem_we = 1'b1;
        end
        else if (state_reg == S_WRITE)
        begin
            mem_we = 1'b1;
            mem_wa = slot_sel[IDX_W-1:0];
            mem_wd = item_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[rd_idx_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (timeout_we)
        begin
            timeout_reg <= timeout_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            out_valid_reg <= 1'b0;
            proc_vld_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && results.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (items.valid)
                    begin
                        func_reg <= items.func;
                        item_reg.node_id <= items.node_id;
                        item_reg.seen_time <= items.seen_time;
                        item_reg.pos_x_bits <= items.pos_x_bits;
                        item_reg.pos_y_bits <= items.pos_y_bits;
                        item_reg.pos_z_bits <= items.pos_z_bits;
                        item_reg.speed_bits <= items.speed_bits;
                        item_reg.heading_bits <= items.heading_bits;
                        now_reg <= items.now_time;
                        rd_idx_reg <= '0;
                        proc_vld_reg <= 1'b0;
                        found_reg <= 1'b0;
                        keep_reg <= '0;
                        removed_reg <= '0;
                        state_reg <= S_SCAN;
                    end
                end

                S_SCAN:
                begin
                    if (rd_idx_reg < count_reg)
                    begin
                        rd_idx_reg <= rd_idx_reg + 1'b1;
                        proc_idx_reg <= rd_idx_reg;
                        proc_vld_reg <= 1'b1;
                    end
                    else
                    begin
                        proc_vld_reg <= 1'b0;
                    end

                    if (proc_vld_reg)
                    begin
                        if (func_reg == FUNC_PURGE)
                        begin
                            if (cmp_lt)
                            begin
                                removed_reg <= removed_reg + 1'b1;
                            end
                            else
                            begin
                                keep_reg <= keep_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            if (!found_reg && rd_data_reg.node_id == item_reg.node_id)
                            begin
                                found_reg <= 1'b1;
                                hit_idx_reg <= proc_idx_reg;
                            end
                            if (proc_idx_reg == '0 || cmp_lt)
                            begin
                                min_seen_reg <= rd_data_reg.seen_time;
                                min_idx_reg <= proc_idx_reg;
                                min_id_reg <= rd_data_reg.node_id;
                            end
                        end
                    end

                    if (scan_end)
                    begin
                        if (func_reg == FUNC_PURGE)
                        begin
                            count_reg <= keep_reg;
                            res_outcome_reg <= OUT_PURGED;
                            res_slot_reg <= '0;
                            res_evicted_reg <= '0;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_WRITE;
                        end
                    end
                end

                S_WRITE:
                begin
                    res_outcome_reg <= outcome_sel;
                    res_slot_reg <= slot_sel;
                    res_evicted_reg <= (outcome_sel == OUT_REPLACED) ? min_id_reg : '0;
                    if (outcome_sel == OUT_APPENDED)
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                    state_reg <= S_DONE;
                end

                S_DONE:
                begin
                    if (!out_valid_reg || results.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_outcome_reg <= res_outcome_reg;
                        out_slot_reg <= res_slot_reg;
                        out_evicted_reg <= res_evicted_reg;
                        out_removed_reg <= removed_reg;
                        out_count_reg <= count_reg;
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign items.ready = (state_reg == S_IDLE);

    assign results.valid = out_valid_reg;
    assign results.outcome = out_outcome_reg;
    assign results.slot = FIELD5_W'(out_slot_reg);
    assign results.evicted_id = out_evicted_reg;
    assign results.removed_count = FIELD5_W'(out_removed_reg);
    assign results.entry_count = FIELD5_W'(out_count_reg);

`ifndef NO_ASSERTIONS
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && mem_we) |-> (keep_reg <= proc_idx_reg))
        else $error("purge copy overtakes the entry being read");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && func_reg == FUNC_PURGE)
            |-> (keep_reg + removed_reg <= count_reg))
        else $error("purge tallies exceed the entry count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_outcome_reg == OUT_REPLACED)
            |-> (out_count_reg == CNT_W'(TABLE_DEPTH)))
        else $error("replacement reported with a table that is not full");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_outcome_reg == OUT_PURGED)
            |-> (out_slot_reg == '0 && out_evicted_reg == '0))
        else $error("purge result carries a slot or an evicted id");
`endif

endmodule

`default_nettype wire
